/* rtl/isd_pkg.sv */
package isd_pkg;

    // field widths
    localparam int unsigned ValueW   = 16;
    localparam int unsigned DiffW    = ValueW + 1;
    localparam int unsigned SqW      = 2 * ValueW;
    localparam int unsigned ScoreW   = 17;

    // running sum, Q.24, saturating at all ones
    localparam int unsigned SumW     = 48;
    // sum plus one in Q.24 needs one more bit
    localparam int unsigned DenW     = SumW + 1;
    // shared adder: shifted remainder plus a sign bit
    localparam int unsigned AddW     = DenW + 2;

    // 1.0 in Q.24
    localparam int unsigned OneFrac  = 24;
    // numerator is 2^40; quotient fits ScoreW bits, so the remainder
    // starts from 2^(40 - ScoreW) and only zero bits are shifted in
    localparam int unsigned NumerExp = 40;
    localparam int unsigned RemInit  = NumerExp - ScoreW;

    localparam int unsigned DivSteps = ScoreW;
    localparam int unsigned CntW     = $clog2(DivSteps);

endpackage

/* rtl/inverse_sq_distance_score.sv */
// inverse squared distance score. each input item carries one pair of
// vector elements (query and key, signed Q3.12) and a last flag. the block
// adds the exact square of their difference to a saturating 48-bit Q.24
// running sum. on the item flagged last it delivers one output item,
// score = floor(2^40 / (2^24 + sum)), i.e. 1/(1 + squared distance) as
// unsigned Q1.16 with 65536 meaning 1.0, and then clears the sum. items
// without the flag give no output. one item is worked on at a time: an
// ordinary element goes through capture and subtract, square, and add
// into the sum; a last element then also forms the divisor and runs 17
// restoring-division steps, one quotient bit a cycle through the single
// shared 51-bit adder, and hands the score to the output register once
// any earlier score has gone. the output register frees the block from
// the consumer: the next item is taken while a score still waits, and only
// a second score stalls until the first has gone.
module inverse_sq_distance_score (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [isd_pkg::ValueW-1:0]    i_q_value,
    input  logic signed [isd_pkg::ValueW-1:0]    i_k_value,
    input  logic                                 i_last_element,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic        [isd_pkg::ScoreW-1:0]    o_score
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_DEN,
        S_DIV,
        S_PUSH
    } t_state;

    localparam logic [isd_pkg::SumW-1:0] SumMax = '1;
    localparam logic [isd_pkg::CntW-1:0] LastStep = isd_pkg::CntW'(isd_pkg::DivSteps - 1);
    localparam logic [isd_pkg::ScoreW-1:0] ScoreOne =
        isd_pkg::ScoreW'(1) << (isd_pkg::ScoreW - 1);

    // control
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_last, n_last;

    // datapath
    logic signed [isd_pkg::DiffW-1:0]  r_diff, n_diff;
    logic        [isd_pkg::SqW-1:0]    r_sq, n_sq;
    logic        [isd_pkg::DenW-1:0]   r_acc, n_acc;   // sum, then divisor
    logic        [isd_pkg::DenW-1:0]   r_rem, n_rem;
    logic        [isd_pkg::ScoreW-1:0] r_quo, n_quo;
    logic        [isd_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic        [isd_pkg::ScoreW-1:0] r_score, n_score;

    // shared adder
    logic [isd_pkg::AddW-1:0] add_a, add_b, add_sum;
    logic                     add_cin;
    logic [isd_pkg::ValueW-1:0] diff_mag;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;

    // magnitude of a 17-bit difference always fits 16 bits
    assign diff_mag = r_diff[isd_pkg::DiffW-1]
                    ? isd_pkg::ValueW'(-r_diff) : isd_pkg::ValueW'(r_diff);

    // one adder: accumulate, bias by 1.0, or trial subtract
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            S_ACC: begin
                add_a = isd_pkg::AddW'(r_acc);
                add_b = isd_pkg::AddW'(r_sq);
            end
            S_DEN: begin
                add_a = isd_pkg::AddW'(r_acc);
                add_b = isd_pkg::AddW'(1) << isd_pkg::OneFrac;
            end
            S_DIV: begin
                add_a   = {1'b0, r_rem, 1'b0};
                add_b   = ~isd_pkg::AddW'(r_acc);
                add_cin = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_sum = add_a + add_b + isd_pkg::AddW'(add_cin);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        n_diff      = r_diff;
        n_sq        = r_sq;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_score     = r_score;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_diff  = isd_pkg::DiffW'(i_q_value) - isd_pkg::DiffW'(i_k_value);
                    n_last  = i_last_element;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_sq    = isd_pkg::SqW'(diff_mag) * isd_pkg::SqW'(diff_mag);
                n_state = S_ACC;
            end
            S_ACC: begin
                // sum below 2^48 plus a square below 2^32: bit 48 flags overflow
                if (add_sum[isd_pkg::SumW]) begin
                    n_acc = isd_pkg::DenW'(SumMax);
                end else begin
                    n_acc = add_sum[isd_pkg::DenW-1:0];
                end
                n_state = r_last ? S_DEN : S_IDLE;
            end
            S_DEN: begin
                n_acc   = add_sum[isd_pkg::DenW-1:0];
                n_rem   = isd_pkg::DenW'(1) << isd_pkg::RemInit;
                n_quo   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // sign bit clear: shifted remainder not below divisor
                if (!add_sum[isd_pkg::AddW-1]) begin
                    n_rem = add_sum[isd_pkg::DenW-1:0];
                end else begin
                    n_rem = {r_rem[isd_pkg::DenW-2:0], 1'b0};
                end
                n_quo = {r_quo[isd_pkg::ScoreW-2:0], ~add_sum[isd_pkg::AddW-1]};
                n_cnt = r_cnt + isd_pkg::CntW'(1);
                if (r_cnt == LastStep) begin
                    n_acc   = '0;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_score     = r_quo;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
        end
        r_diff  <= n_diff;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_score <= n_score;
    end

    // score never above 1.0
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_score <= ScoreOne))
        else $error("score above one");

    // remainder stays below the divisor throughout division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_acc))
        else $error("remainder not below divisor");

    // saturated sum never reaches bit 48 between items
    a_sum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_acc[isd_pkg::SumW])
        else $error("running sum overflow");

    // division step count bounded
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= LastStep))
        else $error("division step count out of range");

    // sum cleared once a score is formed
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_acc == '0))
        else $error("sum not cleared after last item");

endmodule

/* verif/inverse_sq_distance_score_tb.sv */
module inverse_sq_distance_score_tb;

    // run shape
    localparam int          IdlePct    = 12;     // chance in a hundred of a bubble
    localparam int          HoldCycles = 300;    // one long consumer hold-off
    localparam int          HoldAt     = 20;     // scores seen before the hold-off
    localparam int          CalmLo     = 30;     // consumer never stalls for scores
    localparam int          CalmHi     = 55;     // in this window
    localparam int          RandItems  = 280;
    localparam int          MaxDim     = 128;
    localparam int          LongLen    = 2 * MaxDim;  // one vector well past the maximum
    localparam int          TailCycles = 40;     // margin for a last element to finish
    localparam int          WatchLimit = 4000;

    localparam logic [63:0] SumMax     = (64'd1 << isd_pkg::SumW) - 64'd1;
    localparam logic [63:0] OneQ24     = 64'd1 << isd_pkg::OneFrac;
    localparam logic [63:0] NumerQ40   = 64'd1 << isd_pkg::NumerExp;

    localparam logic [isd_pkg::ValueW-1:0] PosMax = 16'h7fff;
    localparam logic [isd_pkg::ValueW-1:0] NegMax = 16'h8000;

    // one pending element pair; no_gap keeps the sender from idling before it
    typedef struct packed {
        logic [isd_pkg::ValueW-1:0] q;
        logic [isd_pkg::ValueW-1:0] k;
        logic                       last;
        logic                       no_gap;
    } t_pair;

    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       o_in_ready;
    logic [isd_pkg::ValueW-1:0] in_q = '0;
    logic [isd_pkg::ValueW-1:0] in_k = '0;
    logic                       in_last = 1'b0;
    logic                       o_out_valid;
    logic                       out_ready = 1'b0;
    logic [isd_pkg::ScoreW-1:0] o_score;

    t_pair                      pair_q[$];    // pairs still to be offered
    logic [isd_pkg::ScoreW-1:0] score_q[$];   // scores predicted but not yet seen
    logic [63:0]       dist_sum = '0;  // predicted running sum of squared differences
    int                pairs_left = 0;
    int                scores_seen = 0;
    int                hold_left = 0;
    bit                held_off = 1'b0;
    int                idle_run = 0;
    int                err_cnt = 0;

    inverse_sq_distance_score u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_q_value      (in_q),
        .i_k_value      (in_k),
        .i_last_element (in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_score        (o_score)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // fold one accepted pair into the predicted sum; on the last element of a
    // vector work out the score from the sum and clear it
    function automatic void fold_pair(logic [isd_pkg::ValueW-1:0] q,
                                      logic [isd_pkg::ValueW-1:0] k, logic last);
        logic [isd_pkg::DiffW-1:0] diff;
        logic [isd_pkg::DiffW-1:0] mag;
        logic [63:0]      sq;
        logic [63:0]      acc;
        logic [63:0]      quot;
        diff = {q[isd_pkg::ValueW-1], q} - {k[isd_pkg::ValueW-1], k};
        mag  = diff[isd_pkg::DiffW-1] ? (~diff + 1'b1) : diff;
        sq   = 64'(mag) * 64'(mag);
        acc  = dist_sum + sq;
        // the sum sticks at all ones rather than wrapping
        dist_sum = (acc > SumMax) ? SumMax : acc;
        if (last) begin
            quot = NumerQ40 / (OneQ24 + dist_sum);
            score_q.push_back(quot[isd_pkg::ScoreW-1:0]);
            dist_sum = '0;
        end
    endfunction

    task automatic queue_pair(logic [isd_pkg::ValueW-1:0] q, logic [isd_pkg::ValueW-1:0] k,
                              logic last, logic no_gap);
        t_pair p;
        p.q      = q;
        p.k      = k;
        p.last   = last;
        p.no_gap = no_gap;
        pair_q.push_back(p);
        pairs_left++;
    endtask

    // sender: one item held until taken, a fresh one loaded on the same edge
    // as the handshake unless a bubble is drawn
    always @(posedge i_clk) begin
        t_pair nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                fold_pair(in_q, in_k, in_last);
                pairs_left--;
            end
            if (!in_valid || o_in_ready) begin
                if (pair_q.size() != 0 &&
                    (pair_q[0].no_gap || $urandom_range(99) >= IdlePct)) begin
                    nxt = pair_q.pop_front();
                    in_q     <= nxt.q;
                    in_k     <= nxt.k;
                    in_last  <= nxt.last;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each score against the oldest prediction, stalls at
    // random, and once holds off long enough for the block to back up
    always @(posedge i_clk) begin
        logic rdy;
        logic [isd_pkg::ScoreW-1:0] want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (score_q.size() == 0) begin
                    $display("%0t: unexpected score, expected none, actual %0d", $time,
                             o_score);
                    err_cnt++;
                end else begin
                    want = score_q.pop_front();
                    if (o_score !== want) begin
                        $display("%0t: score mismatch, expected %0d, actual %0d", $time,
                                 want, o_score);
                        err_cnt++;
                    end
                end
                scores_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!held_off && scores_seen >= HoldAt) begin
                held_off  = 1'b1;
                hold_left = HoldCycles;
                rdy       = 1'b0;
            end else if (scores_seen >= CalmLo && scores_seen < CalmHi) begin
                rdy = 1'b1;
            end else begin
                rdy = ($urandom_range(99) >= IdlePct);
            end
            out_ready <= rdy;
        end
    end

    // watchdog on cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if (!rst_n) begin
            idle_run = 0;
        end else if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= WatchLimit) begin
                $display("inverse_sq_distance_score regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [isd_pkg::ValueW-1:0] q;
        logic [isd_pkg::ValueW-1:0] k;
        logic [isd_pkg::ValueW-1:0] dlt;
        int len;
        int sel;
        int shft;
        int rand_cnt;

        // directed: identical elements give 1.0
        queue_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
        queue_pair(NegMax,   NegMax,   1'b1, 1'b0);
        queue_pair(PosMax,   PosMax,   1'b1, 1'b0);
        // widest differences, both signs
        queue_pair(PosMax,   NegMax,   1'b1, 1'b0);
        queue_pair(NegMax,   PosMax,   1'b1, 1'b0);
        // distance of exactly 1.0 gives one half, one lsb gives just under 1.0
        queue_pair(16'h1000, 16'h0000, 1'b1, 1'b0);
        queue_pair(16'h0001, 16'h0000, 1'b1, 1'b0);
        queue_pair(16'hffff, 16'h0000, 1'b1, 1'b0);
        // elements without the last flag only accumulate
        queue_pair(16'h0064, 16'hff9c, 1'b0, 1'b0);
        queue_pair(16'hfffb, 16'h0007, 1'b0, 1'b0);
        queue_pair(16'h1234, 16'h0fff, 1'b1, 1'b0);
        // a few widest-difference pairs in one vector
        queue_pair(PosMax,   NegMax,   1'b0, 1'b1);
        queue_pair(NegMax,   PosMax,   1'b0, 1'b1);
        queue_pair(PosMax,   NegMax,   1'b0, 1'b1);
        queue_pair(16'h0000, 16'h0000, 1'b1, 1'b1);

        // overlong vector of widest differences, past the nominal maximum
        for (int i = 0; i < LongLen; i++) begin
            if (i % 2 == 0)
                queue_pair(PosMax, NegMax, (i == LongLen - 1), 1'b0);
            else
                queue_pair(NegMax, PosMax, (i == LongLen - 1), 1'b0);
        end
        // the sum must start from zero again afterwards
        queue_pair(16'h0000, 16'h0000, 1'b1, 1'b0);

        // random vectors, mostly short, now and then up to the nominal maximum
        rand_cnt = 0;
        while (rand_cnt < RandItems) begin
            sel = $urandom_range(99);
            if (sel < 70)
                len = $urandom_range(1, 4);
            else if (sel < 95)
                len = $urandom_range(5, 16);
            else
                len = $urandom_range(17, MaxDim);
            for (int e = 0; e < len; e++) begin
                sel = $urandom_range(99);
                q   = 16'($urandom);
                if (sel < 40) begin
                    k = 16'($urandom);
                end else if (sel < 85) begin
                    // near neighbours keep the score away from zero
                    shft = $urandom_range(0, 14);
                    dlt  = 16'($urandom & ((32'd1 << shft) - 32'd1));
                    k    = $urandom_range(1) ? q - dlt : q + dlt;
                end else begin
                    k = q;
                end
                queue_pair(q, k, (e == len - 1),
                           (rand_cnt >= 100 && rand_cnt < 220));
                rand_cnt++;
            end
        end

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // everything sent and every score back, then let the pipe drain
        do @(negedge i_clk);
        while (pairs_left != 0 || score_q.size() != 0);
        repeat (TailCycles) @(negedge i_clk);

        if (err_cnt == 0)
            $display("inverse_sq_distance_score regression: pass");
        else
            $display("inverse_sq_distance_score regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/isd_pkg.sv
rtl/inverse_sq_distance_score.sv
verif/inverse_sq_distance_score_tb.sv
